>>> sv/hash_grid_feature_encoder_unit_defines.svh
// assertion macros used by the hash grid encoder top level
`ifndef HASH_GRID_FEATURE_ENCODER_UNIT_DEFINES_SVH
`define HASH_GRID_FEATURE_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HGFE_ASSERT_IMP(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) else $error(msg);

// next-cycle implication, checked outside reset
`define HGFE_ASSERT_NXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) else $error(msg);

`endif

>>> sv/hgfe_pkg.sv
// package with constants and types of the hash grid feature encoder
package hgfe_pkg;

   localparam int HGFE_LEVELS     = 8;
   localparam int HGFE_FEATURES   = 2;
   localparam int HGFE_LOG2_TABLE = 12;

   localparam int RES_MAX_W  = 25;
   localparam int SIZE_MAX_W = 22;
   localparam int TAB_AW     = 16;

   localparam logic [31:0] HASH_PRIME = 32'd2654435761;

   localparam logic [1:0] CSR_BASE_RES  = 2'd0;
   localparam logic [1:0] CSR_LOG2_SIZE = 2'd1;
   localparam logic [1:0] CSR_ACTIVE    = 2'd2;
   localparam logic [1:0] CSR_LIMIT     = 2'd3;

   localparam logic [9:0]  RST_BASE_RES  = 10'd16;
   localparam logic [3:0]  RST_LOG2_SIZE = 4'd12;
   localparam logic [3:0]  RST_ACTIVE    = 4'd8;
   localparam logic [15:0] RST_LIMIT     = 16'h7FFF;

   typedef struct packed {
      logic                  hashed;
      logic [RES_MAX_W-1:0]  res;
      logic [SIZE_MAX_W-1:0] size;
      logic [TAB_AW-1:0]     base;
   } level_info_type;

endpackage

>>> sv/hash_grid_feature_encoder_unit.sv
// top level of the 2d multiresolution hash grid feature encoder
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-----------------------------
//  request | req_kind/table_address/table_value/     | taken when start && !busy
//          | point_x/point_y                         |
//  result  | rsp_level_index/feature_index/          | rsp_valid, one cycle each
//          | feature_value/last                      |
//  config  | csr_we/csr_index/csr_wdata              | written when csr_we is high
//
// a table write item is written straight into the table memory
// a query item spends one setup state per level, then per (level, feature) four corners
//   of hash, fold, read and capture each, plus interpolation, fade and output; a new
//   item is taken only once the sequencer is back in idle
// a hashed level with a feature count that is not a power of two adds a wait per
//   corner for the bit-serial remainder unit
// the single read port of the table memory sets the pace: four corner reads per result
// after reset and after every register write the layout sequencer rebuilds the level
//   table, with busy high
// results cannot be stalled: each one is shown for one cycle with rsp_valid
`include "hash_grid_feature_encoder_unit_defines.svh"

module hash_grid_feature_encoder_unit #(
   parameter int LEVELS     = hgfe_pkg::HGFE_LEVELS,
   parameter int FEATURES   = hgfe_pkg::HGFE_FEATURES,
   parameter int LOG2_TABLE = hgfe_pkg::HGFE_LOG2_TABLE
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_kind,
   input  logic [15:0]        req_table_address,
   input  logic signed [15:0] req_table_value,
   input  logic [16:0]        req_point_x,
   input  logic [16:0]        req_point_y,
   output logic               rsp_valid,
   output logic [3:0]         rsp_level_index,
   output logic [2:0]         rsp_feature_index,
   output logic signed [15:0] rsp_feature_value,
   output logic               rsp_last,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import hgfe_pkg::*;

   localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int FEAT_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;
   localparam int RES_W  = LEVELS + 9;
   localparam int DW     = (LOG2_TABLE + 2) / 2;
   localparam int SIZE_W = LOG2_TABLE + 3;
   localparam bit FEAT_POW2 = (FEATURES & (FEATURES - 1)) == 0;

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_LEVEL = 4'd1;
   localparam logic [3:0] ST_HASH  = 4'd2;
   localparam logic [3:0] ST_FOLD  = 4'd3;
   localparam logic [3:0] ST_MOD   = 4'd4;
   localparam logic [3:0] ST_READ  = 4'd5;
   localparam logic [3:0] ST_DATA  = 4'd6;
   localparam logic [3:0] ST_LERP1 = 4'd7;
   localparam logic [3:0] ST_LERP2 = 4'd8;
   localparam logic [3:0] ST_MASK  = 4'd9;
   localparam logic [3:0] ST_OUT   = 4'd10;

   // configuration registers
   logic [9:0]  base_res_ff;
   logic [3:0]  log2_size_ff;
   logic [3:0]  active_ff;
   logic [15:0] limit_ff;
   logic        restart_ff;

   // sequencer
   logic [3:0]        state_ff, state_in;
   logic [LVL_W-1:0]  lvl_ff, nlm1_ff;
   logic [FEAT_W-1:0] feat_ff;
   logic [1:0]        corner_ff;
   logic [16:0]       px_ff, py_ff;
   level_info_type    info_ff;
   level_info_type    lay_info;
   logic              lay_busy;

   // per-level coordinates and mask
   logic [RES_W-1:0]    ix_ff, iy_ff;
   logic [15:0]         kx_ff, ky_ff;
   logic                mzero_ff, mfrac_ff;
   logic [7:0]          mfr_ff;

   // index path
   logic [31:0]         h_ff;
   logic [SIZE_W-1:0]   idx_ff;
   logic signed [15:0]  cval_ff [4];

   // interpolation
   logic signed [33:0]  a_ff, b_ff;
   logic signed [51:0]  v_ff;
   logic signed [60:0]  vm_ff;

   // result registers
   logic               rsp_valid_ff;
   logic [3:0]         rsp_level_ff;
   logic [2:0]         rsp_feat_ff;
   logic signed [15:0] rsp_value_ff;
   logic               rsp_last_ff;

   logic               accept;
   logic [4:0]         lg_clamp;
   logic [4:0]         act5;
   logic [LVL_W-1:0]   nlm1;
   logic [16:0]        px_c, py_c;
   logic [RES_W-1:0]   rm1;
   logic [RES_W+16:0]  xf, yf;
   logic signed [20:0] m_val;
   logic [RES_W-1:0]   cx, cy;
   logic [31:0]        h_in;
   logic [31:0]        fold;
   logic [SIZE_W-1:0]  lsize;
   logic [SIZE_W-1:0]  idx_direct;
   logic               mod_start, mod_done;
   logic [SIZE_MAX_W-1:0] mod_rem;
   logic               rd_en;
   logic [TAB_AW-1:0]  rd_addr;
   logic [15:0]        rd_data;
   logic signed [16:0] d10, d32;
   logic signed [33:0] pa, pb;
   logic signed [34:0] dab;
   logic signed [51:0] pv;
   logic signed [60:0] s40;
   logic signed [51:0] s32;
   logic signed [21:0] q;
   logic [15:0]        out_val;
   logic               last_feat, last_lvl;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE) || lay_busy || restart_ff || csr_we;

   // register clamps
   always_comb begin
      if ({1'b0, log2_size_ff} < 5'd4) begin
         lg_clamp = 5'd4;
      end else if ({1'b0, log2_size_ff} > 5'(LOG2_TABLE)) begin
         lg_clamp = 5'(LOG2_TABLE);
      end else begin
         lg_clamp = {1'b0, log2_size_ff};
      end
      act5 = {1'b0, active_ff};
      if (act5 == 5'd0) begin
         nlm1 = '0;
      end else if (act5 > 5'(LEVELS)) begin
         nlm1 = LVL_W'(LEVELS - 1);
      end else begin
         nlm1 = LVL_W'(act5 - 5'd1);
      end
      px_c = (req_point_x > 17'd65536) ? 17'd65536 : req_point_x;
      py_c = (req_point_y > 17'd65536) ? 17'd65536 : req_point_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_res_ff  <= RST_BASE_RES;
         log2_size_ff <= RST_LOG2_SIZE;
         active_ff    <= RST_ACTIVE;
         limit_ff     <= RST_LIMIT;
         restart_ff   <= 1'b1;
      end else begin
         restart_ff <= csr_we;
         if (csr_we) begin
            unique case (csr_index)
               CSR_BASE_RES:  base_res_ff  <= csr_wdata[9:0];
               CSR_LOG2_SIZE: log2_size_ff <= csr_wdata[3:0];
               CSR_ACTIVE:    active_ff    <= csr_wdata[3:0];
               CSR_LIMIT:     limit_ff     <= csr_wdata;
               default:       base_res_ff  <= base_res_ff;
            endcase
         end
      end
   end

   hgfe_layout #(
      .LEVELS     (LEVELS),
      .FEATURES   (FEATURES),
      .LOG2_TABLE (LOG2_TABLE),
      .LVL_W      (LVL_W)
   ) u_layout (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart_ff),
      .base_res  (base_res_ff),
      .log2_size (lg_clamp),
      .busy      (lay_busy),
      .rd_level  (lvl_ff),
      .rd_info   (lay_info)
   );

   // level setup: cell coordinates, weights and fade mask
   always_comb begin
      rm1   = lay_info.res[RES_W-1:0] - RES_W'(1);
      xf    = (RES_W+17)'(px_ff) * (RES_W+17)'(rm1);
      yf    = (RES_W+17)'(py_ff) * (RES_W+17)'(rm1);
      m_val = $signed({{5{limit_ff[15]}}, limit_ff}) + 21'sd256
            - $signed({{(13 - LVL_W){1'b0}}, lvl_ff, 8'b0});
   end

   // corner hash: dense row-major or xor-prime
   always_comb begin
      cx = ix_ff + RES_W'(corner_ff[0]);
      cy = iy_ff + RES_W'(corner_ff[1]);
      if (info_ff.hashed) begin
         h_in = (32'(cy) * HASH_PRIME) ^ 32'(cx);
      end else begin
         h_in = 32'(cy[DW-1:0]) * 32'(info_ff.res[DW-1:0]) + 32'(cx[DW-1:0]);
      end
   end

   // fold in the feature, then reduce to the level size
   always_comb begin
      fold  = (h_ff * 32'(FEATURES)) + 32'(feat_ff);
      lsize = info_ff.size[SIZE_W-1:0];
      if (info_ff.hashed) begin
         idx_direct = fold[SIZE_W-1:0] & (lsize - SIZE_W'(1));
      end else if (fold >= 32'(lsize)) begin
         idx_direct = fold[SIZE_W-1:0] - lsize;
      end else begin
         idx_direct = fold[SIZE_W-1:0];
      end
      mod_start = (state_ff == ST_FOLD) && info_ff.hashed && !FEAT_POW2;
      rd_en     = (state_ff == ST_READ);
      rd_addr   = info_ff.base + TAB_AW'(idx_ff);
   end

   hgfe_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (fold),
      .divisor   (info_ff.size),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   hgfe_table u_table (
      .clock   (clock),
      .wr_en   (accept && !req_kind),
      .wr_addr (req_table_address),
      .wr_data (req_table_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // bilinear interpolation and fade
   always_comb begin
      d10 = $signed({cval_ff[1][15], cval_ff[1]}) - $signed({cval_ff[0][15], cval_ff[0]});
      d32 = $signed({cval_ff[3][15], cval_ff[3]}) - $signed({cval_ff[2][15], cval_ff[2]});
      pa  = d10 * $signed({1'b0, kx_ff});
      pb  = d32 * $signed({1'b0, kx_ff});
      dab = $signed({b_ff[33], b_ff}) - $signed({a_ff[33], a_ff});
      pv  = dab * $signed({1'b0, ky_ff});
      s40 = vm_ff + (61'sd1 <<< 39);
      s32 = v_ff + (52'sd1 <<< 31);
      if (mfrac_ff) begin
         q = 22'($signed(s40[60:40]));
      end else begin
         q = 22'($signed(s32[51:32]));
      end
      if (mzero_ff) begin
         out_val = '0;
      end else if (q > 22'sd32767) begin
         out_val = 16'h7FFF;
      end else if (q < -22'sd32768) begin
         out_val = 16'h8000;
      end else begin
         out_val = q[15:0];
      end
      last_feat = feat_ff == FEAT_W'(FEATURES - 1);
      last_lvl  = lvl_ff == nlm1_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept && req_kind) begin
                      state_in = ST_LEVEL;
                   end
         ST_LEVEL: state_in = ST_HASH;
         ST_HASH:  state_in = ST_FOLD;
         ST_FOLD:  state_in = (info_ff.hashed && !FEAT_POW2) ? ST_MOD : ST_READ;
         ST_MOD:   if (mod_done) begin
                      state_in = ST_READ;
                   end
         ST_READ:  state_in = ST_DATA;
         ST_DATA:  state_in = (corner_ff == 2'd3) ? ST_LERP1 : ST_HASH;
         ST_LERP1: state_in = ST_LERP2;
         ST_LERP2: state_in = ST_MASK;
         ST_MASK:  state_in = ST_OUT;
         ST_OUT: begin
            if (!last_feat) begin
               state_in = ST_HASH;
            end else if (!last_lvl) begin
               state_in = ST_LEVEL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lvl_ff       <= '0;
         feat_ff      <= '0;
         corner_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_OUT);
         if (state_ff == ST_IDLE) begin
            lvl_ff    <= '0;
            feat_ff   <= '0;
            corner_ff <= '0;
         end else if (state_ff == ST_DATA) begin
            corner_ff <= corner_ff + 2'd1;
         end else if (state_ff == ST_OUT) begin
            if (!last_feat) begin
               feat_ff <= feat_ff + FEAT_W'(1);
            end else begin
               feat_ff <= '0;
               lvl_ff  <= lvl_ff + LVL_W'(1);
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept && req_kind) begin
         px_ff   <= px_c;
         py_ff   <= py_c;
         nlm1_ff <= nlm1;
      end
      if (state_ff == ST_LEVEL) begin
         info_ff  <= lay_info;
         ix_ff    <= xf[RES_W+15:16];
         iy_ff    <= yf[RES_W+15:16];
         kx_ff    <= xf[15:0];
         ky_ff    <= yf[15:0];
         mzero_ff <= m_val <= 21'sd0;
         mfrac_ff <= m_val < 21'sd256;
         mfr_ff   <= m_val[7:0];
      end
      if (state_ff == ST_HASH) begin
         h_ff <= h_in;
      end
      if (state_ff == ST_FOLD) begin
         idx_ff <= idx_direct;
      end else if (state_ff == ST_MOD && mod_done) begin
         idx_ff <= mod_rem[SIZE_W-1:0];
      end
      if (state_ff == ST_DATA) begin
         cval_ff[corner_ff] <= rd_data;
      end
      if (state_ff == ST_LERP1) begin
         a_ff <= $signed({{2{cval_ff[0][15]}}, cval_ff[0], 16'b0}) + pa;
         b_ff <= $signed({{2{cval_ff[2][15]}}, cval_ff[2], 16'b0}) + pb;
      end
      if (state_ff == ST_LERP2) begin
         v_ff <= $signed({{2{a_ff[33]}}, a_ff, 16'b0}) + pv;
      end
      if (state_ff == ST_MASK) begin
         vm_ff <= v_ff * $signed({1'b0, mfr_ff});
      end
      if (state_ff == ST_OUT) begin
         rsp_level_ff <= 4'(lvl_ff);
         rsp_feat_ff  <= 3'(feat_ff);
         rsp_value_ff <= out_val;
         rsp_last_ff  <= last_feat && last_lvl;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_level_index   = rsp_level_ff;
   assign rsp_feature_index = rsp_feat_ff;
   assign rsp_feature_value = rsp_value_ff;
   assign rsp_last          = rsp_last_ff;

   // the final item of a point leaves the sequencer idle
   `HGFE_ASSERT_IMP(a_last_idle, rsp_valid && rsp_last, state_ff == ST_IDLE, "sequencer still running after last item")
   // an accepted query keeps the block busy
   `HGFE_ASSERT_NXT(a_query_busy, start && !busy && req_kind, busy, "query accepted but block not busy")
   // items are never shown in two adjacent cycles
   `HGFE_ASSERT_NXT(a_single_strobe, rsp_valid, !rsp_valid, "two result strobes in a row")
   // the remainder unit is only waited on for hashed levels
   `HGFE_ASSERT_IMP(a_mod_hashed, state_ff == ST_MOD, info_ff.hashed, "remainder wait on a dense level")

endmodule

>>> sv/hgfe_table.sv
// feature table memory, one write and one registered read port
module hgfe_table (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [hgfe_pkg::TAB_AW-1:0] wr_addr,
   input  logic [15:0]                wr_data,
   input  logic                       rd_en,
   input  logic [hgfe_pkg::TAB_AW-1:0] rd_addr,
   output logic [15:0]                rd_data
);
   import hgfe_pkg::*;

   logic [15:0] mem [1 << TAB_AW];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/hgfe_layout.sv
// per-level layout sequencer: resolution, size and base offset of each level
module hgfe_layout #(
   parameter int LEVELS     = hgfe_pkg::HGFE_LEVELS,
   parameter int FEATURES   = hgfe_pkg::HGFE_FEATURES,
   parameter int LOG2_TABLE = hgfe_pkg::HGFE_LOG2_TABLE,
   parameter int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    restart,
   input  logic [9:0]              base_res,
   input  logic [4:0]              log2_size,
   output logic                    busy,
   input  logic [LVL_W-1:0]        rd_level,
   output hgfe_pkg::level_info_type rd_info
);
   import hgfe_pkg::*;

   localparam int RES_W  = LEVELS + 9;
   localparam int DW     = (LOG2_TABLE + 2) / 2;
   localparam int CNT_W  = 2 * DW + 1;
   localparam int CELL_W = LOG2_TABLE + 1;
   localparam int SIZE_W = LOG2_TABLE + 3;

   logic                 run_ff;
   logic [LVL_W-1:0]     lvl_ff;
   logic [RES_W-1:0]     r_ff;
   logic [TAB_AW-1:0]    off_ff;

   logic                 hashed_ff [LEVELS];
   logic [RES_W-1:0]     res_ff    [LEVELS];
   logic [SIZE_W-1:0]    size_ff   [LEVELS];
   logic [TAB_AW-1:0]    base_ff   [LEVELS];

   logic [2*DW-1:0]      sq;
   logic [CNT_W-1:0]     cnt;
   logic [CELL_W-1:0]    hs;
   logic                 small_r;
   logic                 hashed;
   logic [CELL_W-1:0]    cells;
   logic [SIZE_W-1:0]    size;
   logic [RES_W-1:0]     r0;

   always_comb begin
      r0      = (base_res < 10'd2) ? RES_W'(2) : RES_W'(base_res);
      small_r = (r_ff >> DW) == '0;
      sq      = r_ff[DW-1:0] * r_ff[DW-1:0];
      cnt     = (CNT_W'(sq) + CNT_W'(7)) & ~CNT_W'(7);
      hs      = CELL_W'(1) << log2_size;
      hashed  = !small_r || (cnt > CNT_W'(hs));
      cells   = hashed ? hs : cnt[CELL_W-1:0];
      size    = SIZE_W'(cells) * SIZE_W'(FEATURES);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         lvl_ff <= '0;
      end else if (restart) begin
         run_ff <= 1'b1;
         lvl_ff <= '0;
      end else if (run_ff) begin
         lvl_ff <= lvl_ff + LVL_W'(1);
         if (lvl_ff == LVL_W'(LEVELS - 1)) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (restart) begin
         r_ff   <= r0;
         off_ff <= '0;
      end else if (run_ff) begin
         r_ff              <= (r_ff << 1) - RES_W'(1);
         off_ff            <= off_ff + TAB_AW'(size);
         hashed_ff[lvl_ff] <= hashed;
         res_ff[lvl_ff]    <= r_ff;
         size_ff[lvl_ff]   <= size;
         base_ff[lvl_ff]   <= off_ff;
      end
   end

   assign busy           = run_ff;
   assign rd_info.hashed = hashed_ff[rd_level];
   assign rd_info.res    = RES_MAX_W'(res_ff[rd_level]);
   assign rd_info.size   = SIZE_MAX_W'(size_ff[rd_level]);
   assign rd_info.base   = base_ff[rd_level];

endmodule

>>> sv/hgfe_mod.sv
// bit-serial remainder unit, one dividend bit per cycle
module hgfe_mod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [31:0]                   dividend,
   input  logic [hgfe_pkg::SIZE_MAX_W-1:0] divisor,
   output logic                          done,
   output logic [hgfe_pkg::SIZE_MAX_W-1:0] remainder
);
   import hgfe_pkg::*;

   logic                  run_ff;
   logic                  done_ff;
   logic [4:0]            cnt_ff;
   logic [31:0]           dvd_ff;
   logic [SIZE_MAX_W-1:0] div_ff;
   logic [SIZE_MAX_W-1:0] rem_ff;
   logic [SIZE_MAX_W:0]   trial;
   logic [SIZE_MAX_W:0]   rem_in;

   always_comb begin
      trial  = {rem_ff, dvd_ff[31]};
      rem_in = (trial >= {1'b0, div_ff}) ? trial - {1'b0, div_ff} : trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         div_ff <= divisor;
         rem_ff <= '0;
      end else if (run_ff) begin
         dvd_ff <= dvd_ff << 1;
         rem_ff <= rem_in[SIZE_MAX_W-1:0];
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> dv/hash_grid_feature_encoder_unit_test.sv
// self-checking testbench for the 2d hash grid feature encoder
`timescale 1ns / 1ps

module hash_grid_feature_encoder_unit_test;
   import hgfe_pkg::*;

   localparam int NLEV       = HGFE_LEVELS;
   localparam int NFEAT      = HGFE_FEATURES;
   localparam int CYCLE_CAP  = 2000000;
   localparam int SETTLE     = 80;

   typedef enum logic {KIND_WRITE = 1'b0, KIND_QUERY = 1'b1} item_kind_type;

   typedef struct {
      item_kind_type kind;
      logic [15:0]   addr;
      logic [15:0]   value;
      logic [16:0]   px;
      logic [16:0]   py;
   } encoder_item_type;

   typedef struct {
      logic [3:0]  level;
      logic [2:0]  feat;
      logic [15:0] value;
      logic        last;
   } feature_result_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_kind;
   logic [15:0]        req_table_address;
   logic signed [15:0] req_table_value;
   logic [16:0]        req_point_x;
   logic [16:0]        req_point_y;
   logic               rsp_valid;
   logic [3:0]         rsp_level_index;
   logic [2:0]         rsp_feature_index;
   logic signed [15:0] rsp_feature_value;
   logic               rsp_last;
   logic               csr_we;
   logic [1:0]         csr_index;
   logic [15:0]        csr_wdata;

   hash_grid_feature_encoder_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_table_address(req_table_address),
      .req_table_value(req_table_value), .req_point_x(req_point_x),
      .req_point_y(req_point_y), .rsp_valid(rsp_valid),
      .rsp_level_index(rsp_level_index), .rsp_feature_index(rsp_feature_index),
      .rsp_feature_value(rsp_feature_value), .rsp_last(rsp_last),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow of the feature table and of the configuration registers
   logic [15:0] shadow_table [0:65535];
   bit          entry_written [0:65535];
   logic [9:0]  cfg_base_res;
   logic [3:0]  cfg_log2_size;
   logic [3:0]  cfg_active;
   logic [15:0] cfg_limit;

   // per-level layout derived from the registers
   longint unsigned lvl_res  [NLEV];
   longint unsigned lvl_size [NLEV];
   logic [31:0]     lvl_base [NLEV];
   bit              lvl_hashed [NLEV];

   encoder_item_type   pending_items [$];
   feature_result_type expected_features [$];

   int  idle_pct;
   int  mismatches = 0;
   int  cycle_count = 0;
   bit  took;

   // rebuild level layout from the shadow registers
   function automatic void rebuild_layout();
      longint unsigned r, hs, cnt, off;
      int lg;
      r = (cfg_base_res < 2) ? 2 : cfg_base_res;
      lg = cfg_log2_size;
      if (lg < 4) lg = 4;
      if (lg > HGFE_LOG2_TABLE) lg = HGFE_LOG2_TABLE;
      hs = longint'(1) << lg;
      off = 0;
      for (int l = 0; l < NLEV; l++) begin
         cnt = (r * r + 7) & ~64'd7;
         lvl_hashed[l] = cnt > hs;
         if (cnt > hs) cnt = hs;
         lvl_size[l] = cnt * NFEAT;
         lvl_res[l] = r;
         lvl_base[l] = 32'(off & 64'hFFFF);
         off += cnt * NFEAT;
         r = (r - 1) * 2 + 1;
      end
   endfunction

   function automatic int levels_in_use();
      int nl;
      nl = cfg_active;
      if (nl < 1) nl = 1;
      if (nl > NLEV) nl = NLEV;
      return nl;
   endfunction

   // flat table address of one corner entry
   function automatic logic [15:0] corner_addr(int l, logic [31:0] x, logic [31:0] y, int f);
      logic [31:0] h, idx;
      if (lvl_hashed[l]) h = (y * HASH_PRIME) ^ x;
      else h = y * lvl_res[l][31:0] + x;
      idx = (h * 32'(NFEAT) + 32'(f)) % lvl_size[l][31:0];
      return 16'(lvl_base[l] + idx);
   endfunction

   function automatic logic [16:0] clamp_coord(logic [16:0] p);
      return (p > 17'd65536) ? 17'd65536 : p;
   endfunction

   function automatic logic [15:0] round_sat(longint v, int s);
      longint q;
      q = (v + (longint'(1) <<< (s - 1))) >>> s;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   // interpolated, masked features of one query point, level-major
   function automatic void predict_features(logic [16:0] px_in, logic [16:0] py_in);
      longint unsigned xf, yf;
      logic [31:0] ix, iy;
      longint kx, ky, v00, v10, v01, v11, a, b, v;
      int nl, m;
      feature_result_type res;
      nl = levels_in_use();
      for (int l = 0; l < nl; l++) begin
         xf = longint'(clamp_coord(px_in)) * (lvl_res[l] - 1);
         yf = longint'(clamp_coord(py_in)) * (lvl_res[l] - 1);
         ix = xf[47:16];
         iy = yf[47:16];
         kx = longint'(xf[15:0]);
         ky = longint'(yf[15:0]);
         m = int'($signed(cfg_limit)) + 256 - 256 * l;
         for (int f = 0; f < NFEAT; f++) begin
            v00 = longint'($signed(shadow_table[corner_addr(l, ix, iy, f)]));
            v10 = longint'($signed(shadow_table[corner_addr(l, ix + 1, iy, f)]));
            v01 = longint'($signed(shadow_table[corner_addr(l, ix, iy + 1, f)]));
            v11 = longint'($signed(shadow_table[corner_addr(l, ix + 1, iy + 1, f)]));
            a = v00 * 65536 + (v10 - v00) * kx;
            b = v01 * 65536 + (v11 - v01) * kx;
            v = a * 65536 + (b - a) * ky;
            if (m <= 0) res.value = 16'd0;
            else if (m < 256) res.value = round_sat(v * m, 40);
            else res.value = round_sat(v, 32);
            res.level = 4'(l);
            res.feat = 3'(f);
            res.last = (l == nl - 1) && (f == NFEAT - 1);
            expected_features.insert(expected_features.size(), res);
         end
      end
   endfunction

   task automatic queue_write(logic [15:0] addr, logic [15:0] value);
      encoder_item_type it;
      it = '{KIND_WRITE, addr, value, 17'd0, 17'd0};
      entry_written[addr] = 1'b1;
      pending_items.insert(pending_items.size(), it);
   endtask

   // a query first gets writes for any corner entry that was never written
   task automatic queue_query(logic [16:0] px, logic [16:0] py);
      encoder_item_type it;
      longint unsigned xf, yf;
      logic [31:0] ix, iy;
      logic [15:0] ad;
      for (int l = 0; l < levels_in_use(); l++) begin
         xf = longint'(clamp_coord(px)) * (lvl_res[l] - 1);
         yf = longint'(clamp_coord(py)) * (lvl_res[l] - 1);
         ix = xf[47:16];
         iy = yf[47:16];
         for (int f = 0; f < NFEAT; f++)
            for (int c = 0; c < 4; c++) begin
               ad = corner_addr(l, ix + (c & 1), iy + (c >> 1), f);
               if (!entry_written[ad]) queue_write(ad, 16'($urandom));
            end
      end
      it = '{KIND_QUERY, 16'($urandom), 16'($urandom), px, py};
      pending_items.insert(pending_items.size(), it);
   endtask

   function automatic logic [16:0] pick_coord();
      int sel;
      sel = $urandom_range(99);
      if (sel < 70) return 17'($urandom_range(65536));
      if (sel < 80) return 17'd0;
      if (sel < 90) return 17'd65536;
      return 17'($urandom_range(131071, 65537));
   endfunction

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 30) queue_write(16'($urandom), 16'($urandom));
         else queue_query(pick_coord(), pick_coord());
      end
   endtask

   // wait for the block to drain, then write all four registers
   task automatic program_registers(logic [15:0] base_w, logic [15:0] log2_w,
                                    logic [15:0] active_w, logic [15:0] limit_w);
      logic [15:0] vals [4];
      logic [1:0]  idx [4];
      vals = '{base_w, log2_w, active_w, limit_w};
      idx  = '{CSR_BASE_RES, CSR_LOG2_SIZE, CSR_ACTIVE, CSR_LIMIT};
      while (pending_items.size() != 0 || start || expected_features.size() != 0 || busy)
         @(posedge clock);
      // a trailing write item may still be in flight
      repeat (SETTLE) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         @(negedge clock);
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
      end
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_base_res  = base_w[9:0];
      cfg_log2_size = log2_w[3:0];
      cfg_active    = active_w[3:0];
      cfg_limit     = limit_w;
      rebuild_layout();
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // item driver: inputs change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
            encoder_item_type it;
            it = pending_items.pop_front();
            start <= 1'b1;
            req_kind <= it.kind;
            req_table_address <= it.addr;
            req_table_value <= it.value;
            req_point_x <= it.px;
            req_point_y <= it.py;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check results, then predict for the item taken at this edge
   always @(posedge clock) begin
      feature_result_type exp_r;
      if (reset) begin
         took <= 1'b0;
      end else begin
         if (rsp_valid) begin
            if (expected_features.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: level %0d feature %0d value %0d last %0b",
                           rsp_level_index, rsp_feature_index, rsp_feature_value, rsp_last);
            end else begin
               exp_r = expected_features.pop_front();
               if (rsp_level_index !== exp_r.level || rsp_feature_index !== exp_r.feat ||
                   rsp_feature_value !== exp_r.value || rsp_last !== exp_r.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                              exp_r.level, exp_r.feat, $signed(exp_r.value), exp_r.last,
                              rsp_level_index, rsp_feature_index, rsp_feature_value,
                              rsp_last);
               end
            end
         end
         took <= start && !busy;
         if (start && !busy) begin
            // table write updates the shadow; a query predicts its features
            if (req_kind == KIND_WRITE) shadow_table[req_table_address] = req_table_value;
            else predict_features(req_point_x, req_point_y);
         end
      end
   end

   // watchdog on total cycles
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("Verification failed");
         $finish;
      end
   end

   // stimulus sequence across register settings
   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_kind = KIND_WRITE;
      req_table_address = '0;
      req_table_value = '0;
      req_point_x = '0;
      req_point_y = '0;
      csr_we = 1'b0;
      csr_index = CSR_BASE_RES;
      csr_wdata = '0;
      idle_pct = 37;
      cfg_base_res  = RST_BASE_RES;
      cfg_log2_size = RST_LOG2_SIZE;
      cfg_active    = RST_ACTIVE;
      cfg_limit     = RST_LIMIT;
      rebuild_layout();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extreme table entries and corner points at reset settings
      queue_write(16'h0000, 16'h8000);
      queue_write(16'hFFFF, 16'h7FFF);
      queue_write(16'h5AA5, 16'h0000);
      queue_write(16'hA55A, 16'hFFFF);
      queue_query(17'd0, 17'd0);
      queue_query(17'd65536, 17'd65536);

      // coarsest settings, every level masked to zero
      program_registers(16'd2, 16'd4, 16'd1, 16'h8000);
      queue_random(20);

      // register values below range are clamped up
      idle_pct = 54;
      program_registers(16'd0, 16'd0, 16'd0, 16'h0100);
      queue_random(25);

      // all-ones writes: clamped table size and level count, fading levels
      program_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0180);
      queue_query(17'd32768, 17'd32768);

      // dense and hashed level with a fractional mask on the second
      idle_pct = 0;
      program_registers(16'd3, 16'd4, 16'd2, 16'h0080);
      queue_random(50);

      // negative detail level: fractional first level, second masked out
      program_registers(16'd2, 16'd4, 16'd2, 16'hFFC0);
      queue_random(25);

      while (pending_items.size() != 0 || start || expected_features.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+sv
sv/hgfe_pkg.sv
sv/hgfe_table.sv
sv/hgfe_layout.sv
sv/hgfe_mod.sv
sv/hash_grid_feature_encoder_unit.sv
dv/hash_grid_feature_encoder_unit_test.sv
